### design/spsl_pkg.sv
// ============================================================================
// spsl_pkg: shared types and constants of the servo pulse slew limiter
// Request codes, register indexes, controller states and the command and
// status bundles passed between controller and datapath.
// ============================================================================
package spsl_pkg;

  // Request type codes
  localparam logic REQ_TICK   = 1'b0;
  localparam logic REQ_TARGET = 1'b1;

  // Velocity mode codes (the unused code keeps step and limit)
  localparam logic [1:0] VEL_KEEP = 2'd0;
  localparam logic [1:0] VEL_SET  = 2'd1;
  localparam logic [1:0] VEL_OFF  = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 3'd5;

  // Register reset values
  localparam logic [11:0] MIN_PW_RST    = 12'd600;
  localparam logic [11:0] MAX_PW_RST    = 12'd2400;
  localparam logic [15:0] MAX_VEL_RST   = 16'd500;
  localparam logic [7:0]  MIN_ANGLE_RST = 8'd0;
  localparam logic [7:0]  MAX_ANGLE_RST = 8'd180;
  localparam logic [15:0] PULSE_RST     = 16'd1500;
  localparam logic [15:0] STEP_RST      = 16'd100;

  // Angle and percent ceilings
  localparam logic [7:0] ANGLE_FULL = 8'd180;
  localparam logic [7:0] PCT_FULL   = 8'd100;

  // Reciprocal of 180 in 20 fractional bits, exact for spans up to 4095
  localparam logic [12:0] RECIP_180   = 13'd5826;
  localparam int unsigned RECIP_SHIFT = 20;

  // Step division by 900000 on a 35-bit dividend: drop the factor 32, then
  // multiply by the reciprocal of 28125 in 45 fractional bits, exact for
  // every 30-bit value left after the shift
  localparam int unsigned DIV_W            = 35;
  localparam logic [DIV_W-1:0] STEP_DIVISOR = 35'd900000;
  localparam int unsigned STEP_PRE_SHIFT   = 5;
  localparam logic [30:0] STEP_RECIP       = 31'd1250999897;
  localparam int unsigned STEP_RECIP_SHIFT = 45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_SPAN,
    ST_PULSE,
    ST_CLAMP,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load_in;
    logic do_tick;
    logic do_span;
    logic do_pulse;
    logic do_clamp;
    logic div_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic req_target;
    logic need_div;
  } dp_status_t;

endpackage

### design/spsl_ctrl.sv
// ============================================================================
// spsl_ctrl: request sequencer
// Walks each accepted request through the datapath steps and owns the
// output valid flag.
// ============================================================================
module spsl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  spsl_pkg::dp_status_t  status,
  output spsl_pkg::ctrl_cmd_t   cmd
);
  import spsl_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // State and output flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_TICK;
        end
      end
      ST_TICK: begin
        // the captured request decides which path runs
        if (status.req_target) begin
          cmd.do_span = 1'b1;
          state_nxt   = ST_PULSE;
        end else begin
          cmd.do_tick = 1'b1;
          state_nxt   = ST_DONE;
        end
      end
      ST_SPAN: begin
        cmd.do_span = 1'b1;
        state_nxt   = ST_PULSE;
      end
      ST_PULSE: begin
        cmd.do_pulse = 1'b1;
        state_nxt    = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.do_clamp = 1'b1;
        if (status.need_div) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Set on a new result, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

### design/spsl_dp.sv
// ============================================================================
// spsl_dp: slew limiter datapath
// Configuration registers, angle-to-pulse mapping, window clamp, velocity
// step division, pulse state and the output register.
// ============================================================================
module spsl_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  spsl_pkg::ctrl_cmd_t                   cmd,
  output spsl_pkg::dp_status_t                  status,
  input  logic                                  cfg_we,
  input  logic [spsl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [spsl_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_req_type,
  input  logic [7:0]                            in_target_angle,
  input  logic [1:0]                            in_velocity_mode,
  input  logic [7:0]                            in_velocity_pct,
  output logic [15:0]                           out_next_pulse,
  output logic [15:0]                           out_current_pulse,
  output logic [15:0]                           out_destination_pulse,
  output logic                                  out_limit_active
);
  import spsl_pkg::*;

  // Map an angle to a pulse width, wrapping at 16 bits
  function automatic logic [15:0] angle_pulse(input logic [5:0] per,
                                              input logic [7:0] ang,
                                              input logic [11:0] minw);
    logic [15:0] per_x;
    logic [15:0] ang_x;
    logic [15:0] prod;
    per_x = {{10{per[5]}}, per};
    ang_x = {8'd0, ang};
    prod  = per_x * ang_x;
    return prod + {4'd0, minw};
  endfunction

  // Configuration registers
  logic [11:0] min_pw_r, max_pw_r;
  logic [15:0] max_vel_r;
  logic        invert_r;
  logic [7:0]  min_angle_r, max_angle_r;

  // Pulse state
  logic [15:0] cur_r, next_r, dest_r, step_r;
  logic        limit_r;

  // Captured request
  logic        req_r;
  logic [7:0]  angle_r;
  logic [1:0]  mode_r;
  logic [7:0]  pct_r;

  // Command pipeline
  logic [5:0]       per_r;
  logic             neg_r;
  logic [22:0]      prod1_r;
  logic [DIV_W-1:0] prod2_r;
  logic [15:0]      lo_r, hi_r, dpls_r;

  // Output register
  logic [15:0] o_next_r, o_cur_r, o_dest_r;
  logic        o_limit_r;

  // Combinational helpers
  logic [12:0]      span;
  logic             span_neg;
  logic [11:0]      span_abs;
  logic [24:0]      per_prod;
  logic [4:0]       per_mag;
  logic [6:0]       pct_c;
  logic [7:0]       ang_c, ang_m, lo_ang, hi_ang;
  logic [15:0]      clamp_hi, clamp_d;
  logic [15:0]      up_sum, dn_diff, tick_next;
  logic [29:0]      step_y;
  logic [60:0]      step_prod;
  logic [15:0]      step_quo;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_pw_r    <= MIN_PW_RST;
      max_pw_r    <= MAX_PW_RST;
      max_vel_r   <= MAX_VEL_RST;
      invert_r    <= 1'b0;
      min_angle_r <= MIN_ANGLE_RST;
      max_angle_r <= MAX_ANGLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_PW:    min_pw_r    <= cfg_wdata[11:0];
        CFG_MAX_PW:    max_pw_r    <= cfg_wdata[11:0];
        CFG_MAX_VEL:   max_vel_r   <= cfg_wdata;
        CFG_INVERT:    invert_r    <= cfg_wdata[0];
        CFG_MIN_ANGLE: min_angle_r <= cfg_wdata[7:0];
        CFG_MAX_ANGLE: max_angle_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Span, per-degree slope magnitude and clamped percent
  assign span     = {1'b0, max_pw_r} - {1'b0, min_pw_r};
  assign span_neg = span[12];
  assign span_abs = span_neg ? 12'(-span) : span[11:0];
  assign per_prod = {13'd0, span_abs} * {12'd0, RECIP_180};
  assign per_mag  = per_prod[RECIP_SHIFT+4:RECIP_SHIFT];
  assign pct_c    = (pct_r > PCT_FULL) ? PCT_FULL[6:0] : pct_r[6:0];

  // Angles: clamp, mirror, window ends
  assign ang_c  = (angle_r > ANGLE_FULL) ? ANGLE_FULL : angle_r;
  assign ang_m  = invert_r ? (ANGLE_FULL - ang_c) : ang_c;
  assign lo_ang = invert_r ? (ANGLE_FULL - max_angle_r) : min_angle_r;
  assign hi_ang = invert_r ? (ANGLE_FULL - min_angle_r) : max_angle_r;

  // Clamp to hi first, then lo
  assign clamp_hi = (dpls_r > hi_r) ? hi_r : dpls_r;
  assign clamp_d  = (clamp_hi < lo_r) ? lo_r : clamp_hi;

  // Tick: move next pulse toward destination
  assign up_sum  = next_r + step_r;
  assign dn_diff = next_r - step_r;
  always_comb begin
    tick_next = next_r;
    if (!limit_r) begin
      tick_next = dest_r;
    end else if (dest_r > next_r) begin
      tick_next = (up_sum > dest_r) ? dest_r : up_sum;
    end else if (dest_r < next_r) begin
      tick_next = (dn_diff < dest_r) ? dest_r : dn_diff;
    end
  end

  // Step quotient: shift out the factor 32, multiply by the reciprocal
  assign step_y    = prod2_r[DIV_W-1:STEP_PRE_SHIFT];
  assign step_prod = {31'd0, step_y} * {30'd0, STEP_RECIP};
  assign step_quo  = step_prod[STEP_RECIP_SHIFT+15:STEP_RECIP_SHIFT];

  // Capture the request and run the command pipeline
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r   <= in_req_type;
      angle_r <= in_target_angle;
      mode_r  <= in_velocity_mode;
      pct_r   <= in_velocity_pct;
    end
    if (cmd.do_span) begin
      per_r   <= span_neg ? 6'(-{1'b0, per_mag}) : {1'b0, per_mag};
      neg_r   <= span_neg;
      prod1_r <= {7'd0, max_vel_r} * {16'd0, pct_c};
    end
    if (cmd.do_pulse) begin
      lo_r    <= angle_pulse(per_r, lo_ang, min_pw_r);
      hi_r    <= angle_pulse(per_r, hi_ang, min_pw_r);
      dpls_r  <= angle_pulse(per_r, ang_m, min_pw_r);
      prod2_r <= {12'd0, prod1_r} * {23'd0, span_abs};
    end
    if (cmd.load_out) begin
      o_next_r  <= next_r;
      o_cur_r   <= cur_r;
      o_dest_r  <= dest_r;
      o_limit_r <= limit_r;
    end
  end

  // Pulse state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= PULSE_RST;
      next_r  <= PULSE_RST;
      dest_r  <= PULSE_RST;
      step_r  <= STEP_RST;
      limit_r <= 1'b0;
    end else begin
      if (cmd.do_tick) begin
        cur_r  <= next_r;
        next_r <= tick_next;
      end
      if (cmd.do_clamp) begin
        dest_r <= clamp_d;
        if (mode_r == VEL_SET) begin
          limit_r <= 1'b1;
          if (neg_r) begin
            step_r <= '0;
          end
        end else if (mode_r == VEL_OFF) begin
          limit_r <= 1'b0;
        end
      end
      if (cmd.div_step) begin
        step_r <= step_quo;
      end
    end
  end

  assign status.req_target = (req_r == REQ_TARGET);
  assign status.need_div   = (mode_r == VEL_SET) && !neg_r;

  assign out_next_pulse        = o_next_r;
  assign out_current_pulse     = o_cur_r;
  assign out_destination_pulse = o_dest_r;
  assign out_limit_active      = o_limit_r;

endmodule

### design/servo_pulse_slew_limiter.sv
// ============================================================================
// servo_pulse_slew_limiter: servo set-point slew-rate limiter
// Converts target angles into clamped pulse widths and walks the sent pulse
// toward the target by a bounded step on each 50 Hz tick.
// ============================================================================
// One request is worked on at a time and each gives one result. A tick
// request passes the tick and done states; a target command passes the
// tick, pulse, clamp and done states, and one that sets the velocity step
// also the division state, which divides by a reciprocal multiply. The result
// sits in an output register, so the next request is taken while the
// previous result still waits; a second finished request holds until that
// result is taken. Write configuration only while no request is in flight;
// it is used by the next request.
module servo_pulse_slew_limiter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [spsl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spsl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [7:0]                        in_target_angle,
  input  logic [1:0]                        in_velocity_mode,
  input  logic [7:0]                        in_velocity_pct,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [15:0]                       out_next_pulse,
  output logic [15:0]                       out_current_pulse,
  output logic [15:0]                       out_destination_pulse,
  output logic                              out_limit_active
);
  import spsl_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Request sequencer
  spsl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath
  spsl_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_req_type           (in_req_type),
    .in_target_angle       (in_target_angle),
    .in_velocity_mode      (in_velocity_mode),
    .in_velocity_pct       (in_velocity_pct),
    .out_next_pulse        (out_next_pulse),
    .out_current_pulse     (out_current_pulse),
    .out_destination_pulse (out_destination_pulse),
    .out_limit_active      (out_limit_active)
  );

endmodule

### design/spsl_checker.sv
// ============================================================================
// spsl_checker: port-level checks of the slew limiter
// Watches the request and result handshakes of the top level.
// ============================================================================
module spsl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_next_pulse,
  input logic [15:0] out_current_pulse,
  input logic [15:0] out_destination_pulse,
  input logic        out_limit_active
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pulse)
      && $stable(out_current_pulse) && $stable(out_destination_pulse)
      && $stable(out_limit_active))
    else $error("stalled result changed");

  // One request at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // A new result only comes from a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without work");

  // Reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind servo_pulse_slew_limiter spsl_checker u_spsl_checker (.*);
